// ===== hdl/bls_pkg.sv =====
// Shared types and constants for the Bresenham line stepper.
// Used by bls_load_calc, bls_stepper and bresenham_line_stepper_unit.
`timescale 1ns / 1ps

package bls_pkg;

  // Command codes carried in the input beat.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // Per-axis step codes; these are the two's complement values -1, 0 and +1.
  localparam logic [1:0] SIGN_ZERO = 2'b00;
  localparam logic [1:0] SIGN_POS  = 2'b01;
  localparam logic [1:0] SIGN_NEG  = 2'b11;

  // Direction of a line, worked out once at load time.
  typedef struct packed {
    logic [1:0] step_x_sign;
    logic [1:0] step_y_sign;
    logic       axes_swapped;
  } line_dir_t;

endpackage

// ===== hdl/bls_load_calc.sv =====
// Line setup logic: step signs, major/minor deltas and initial decision term.
// Depends on bls_pkg.
`timescale 1ns / 1ps

module bls_load_calc
  import bls_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic [COORD_BITS-1:0]        x_start,
  input  logic [COORD_BITS-1:0]        y_start,
  input  logic [COORD_BITS-1:0]        x_end,
  input  logic [COORD_BITS-1:0]        y_end,
  output line_dir_t                    dir,
  output logic [COORD_BITS-1:0]        major_delta,
  output logic [COORD_BITS-1:0]        minor_delta,
  output logic signed [COORD_BITS+2:0] decision_init
);

  logic signed [COORD_BITS:0]   dx;
  logic signed [COORD_BITS:0]   dy;
  logic [COORD_BITS-1:0]        adx;
  logic [COORD_BITS-1:0]        ady;
  logic                         swapped;

  assign dx = $signed({1'b0, x_end}) - $signed({1'b0, x_start});
  assign dy = $signed({1'b0, y_end}) - $signed({1'b0, y_start});

  assign adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
  assign ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];

  // Ties keep x as the major axis.
  assign swapped = (ady > adx);

  always_comb begin
    if (dx[COORD_BITS]) begin
      dir.step_x_sign = SIGN_NEG;
    end else if (dx == '0) begin
      dir.step_x_sign = SIGN_ZERO;
    end else begin
      dir.step_x_sign = SIGN_POS;
    end
    if (dy[COORD_BITS]) begin
      dir.step_y_sign = SIGN_NEG;
    end else if (dy == '0) begin
      dir.step_y_sign = SIGN_ZERO;
    end else begin
      dir.step_y_sign = SIGN_POS;
    end
    dir.axes_swapped = swapped;
  end

  assign major_delta = swapped ? ady : adx;
  assign minor_delta = swapped ? adx : ady;

  assign decision_init = $signed({2'b00, minor_delta, 1'b0})
                       - $signed({3'b000, major_delta});

endmodule

// ===== hdl/bls_stepper.sv =====
// Line state registers and the per-pixel Bresenham update.
// Depends on bls_pkg; setup values come from bls_load_calc.
`timescale 1ns / 1ps

module bls_stepper
  import bls_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         proc,
  input  logic                         is_load,
  input  logic [COORD_BITS-1:0]        x_start,
  input  logic [COORD_BITS-1:0]        y_start,
  input  line_dir_t                    load_dir,
  input  logic [COORD_BITS-1:0]        load_major,
  input  logic [COORD_BITS-1:0]        load_minor,
  input  logic signed [COORD_BITS+2:0] load_decision,
  output logic                         line_active,
  output logic [COORD_BITS-1:0]        pix_x,
  output logic [COORD_BITS-1:0]        pix_y,
  output logic                         pix_last
);

  logic [COORD_BITS-1:0]        cur_x_r, cur_x_nxt;
  logic [COORD_BITS-1:0]        cur_y_r, cur_y_nxt;
  logic signed [COORD_BITS+2:0] decision_r, decision_nxt;
  logic [COORD_BITS-1:0]        major_r, major_nxt;
  logic [COORD_BITS-1:0]        minor_r, minor_nxt;
  logic [COORD_BITS:0]          remaining_r, remaining_nxt;
  line_dir_t                    dir_r, dir_nxt;
  logic                         active_r, active_nxt;

  logic [COORD_BITS-1:0]        x_inc;
  logic [COORD_BITS-1:0]        y_inc;
  logic [COORD_BITS-1:0]        x_moved;
  logic [COORD_BITS-1:0]        y_moved;
  logic signed [COORD_BITS+2:0] major_x2;
  logic signed [COORD_BITS+2:0] minor_x2;
  logic                         minor_move;

  assign line_active = active_r;
  assign pix_x       = cur_x_r;
  assign pix_y       = cur_y_r;
  assign pix_last    = (remaining_r == (COORD_BITS+1)'(1));

  // Sign codes are two's complement, so sign extension gives the increment.
  assign x_inc   = {{(COORD_BITS-2){dir_r.step_x_sign[1]}}, dir_r.step_x_sign};
  assign y_inc   = {{(COORD_BITS-2){dir_r.step_y_sign[1]}}, dir_r.step_y_sign};
  assign x_moved = cur_x_r + x_inc;
  assign y_moved = cur_y_r + y_inc;

  assign major_x2   = $signed({2'b00, major_r, 1'b0});
  assign minor_x2   = $signed({2'b00, minor_r, 1'b0});
  assign minor_move = !decision_r[COORD_BITS+2];

  always_comb begin
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    decision_nxt  = decision_r;
    major_nxt     = major_r;
    minor_nxt     = minor_r;
    remaining_nxt = remaining_r;
    dir_nxt       = dir_r;
    active_nxt    = active_r;
    if (proc) begin
      if (is_load) begin
        cur_x_nxt     = x_start;
        cur_y_nxt     = y_start;
        decision_nxt  = load_decision;
        major_nxt     = load_major;
        minor_nxt     = load_minor;
        remaining_nxt = {1'b0, load_major} + (COORD_BITS+1)'(1);
        dir_nxt       = load_dir;
        active_nxt    = 1'b1;
      end else if (active_r) begin
        if (remaining_r <= (COORD_BITS+1)'(1)) begin
          // The end point has just gone out; the line is finished.
          remaining_nxt = '0;
          active_nxt    = 1'b0;
        end else begin
          if (dir_r.axes_swapped) begin
            cur_y_nxt = y_moved;
            if (minor_move) begin
              cur_x_nxt = x_moved;
            end
          end else begin
            cur_x_nxt = x_moved;
            if (minor_move) begin
              cur_y_nxt = y_moved;
            end
          end
          decision_nxt  = minor_move ? (decision_r - major_x2 + minor_x2)
                                     : (decision_r + minor_x2);
          remaining_nxt = remaining_r - (COORD_BITS+1)'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      decision_r  <= '0;
      major_r     <= '0;
      minor_r     <= '0;
      remaining_r <= '0;
      dir_r       <= '0;
      active_r    <= 1'b0;
    end else begin
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      decision_r  <= decision_nxt;
      major_r     <= major_nxt;
      minor_r     <= minor_nxt;
      remaining_r <= remaining_nxt;
      dir_r       <= dir_nxt;
      active_r    <= active_nxt;
    end
  end

endmodule

// ===== hdl/bresenham_line_stepper_unit.sv =====
// Bresenham line stepper top level: input beat register, line setup, stepper
// state and the result register. Depends on bls_pkg, bls_load_calc, bls_stepper.
//
// Usage: an input beat with in_cmd = load carries both endpoints and sets up
// a new line; it produces no result. Each following beat with in_cmd = step
// produces one pixel on the out_ channel, and the end point carries
// out_last = 1. A line covers max(|dx|,|dy|)+1 points and needs one step beat
// for each; step beats with no line in progress produce nothing. A load in
// the middle of a line drops the old line.
// An accepted beat sits in the input register until it is worked; a step beat
// then loads its pixel into the result register, from which out_ presents it.
// Throughput: one beat per clock while the result register can take a pixel,
// with the stepper's decision and coordinate registers updated for each beat.
// Reset (rst_n low, synchronous) empties both registers and leaves no line
// in progress. While out_stall is high the pending pixel holds; a step beat
// behind it waits and raises in_stall, while a load beat or a step beat with
// no line in progress still passes.
`timescale 1ns / 1ps

module bresenham_line_stepper_unit
  import bls_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_cmd,
  input  logic [COORD_BITS-1:0] in_x_start,
  input  logic [COORD_BITS-1:0] in_y_start,
  input  logic [COORD_BITS-1:0] in_x_end,
  input  logic [COORD_BITS-1:0] in_y_end,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] out_pixel_x,
  output logic [COORD_BITS-1:0] out_pixel_y,
  output logic                  out_last
);

  logic                         in_valid_r;
  logic                         cmd_r;
  logic [COORD_BITS-1:0]        x_start_r;
  logic [COORD_BITS-1:0]        y_start_r;
  logic [COORD_BITS-1:0]        x_end_r;
  logic [COORD_BITS-1:0]        y_end_r;

  logic                         out_valid_r, out_valid_nxt;
  logic [COORD_BITS-1:0]        pixel_x_r;
  logic [COORD_BITS-1:0]        pixel_y_r;
  logic                         last_r;

  line_dir_t                    load_dir;
  logic [COORD_BITS-1:0]        load_major;
  logic [COORD_BITS-1:0]        load_minor;
  logic signed [COORD_BITS+2:0] load_decision;

  logic                         line_active;
  logic [COORD_BITS-1:0]        pix_x;
  logic [COORD_BITS-1:0]        pix_y;
  logic                         pix_last;

  logic                         is_load;
  logic                         emits;
  logic                         out_free;
  logic                         proc;
  logic                         in_take;

  assign is_load  = (cmd_r == CMD_LOAD);
  assign emits    = (cmd_r == CMD_STEP) && line_active;
  assign out_free = !out_valid_r || !out_stall;
  // Only a beat that produces a pixel needs room in the result register.
  assign proc     = in_valid_r && (!emits || out_free);
  assign in_stall = in_valid_r && !proc;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r     <= in_cmd;
      x_start_r <= in_x_start;
      y_start_r <= in_y_start;
      x_end_r   <= in_x_end;
      y_end_r   <= in_y_end;
    end
  end

  bls_load_calc #(
    .COORD_BITS(COORD_BITS)
  ) u_load_calc (
    .x_start      (x_start_r),
    .y_start      (y_start_r),
    .x_end        (x_end_r),
    .y_end        (y_end_r),
    .dir          (load_dir),
    .major_delta  (load_major),
    .minor_delta  (load_minor),
    .decision_init(load_decision)
  );

  bls_stepper #(
    .COORD_BITS(COORD_BITS)
  ) u_stepper (
    .clk          (clk),
    .rst_n        (rst_n),
    .proc         (proc),
    .is_load      (is_load),
    .x_start      (x_start_r),
    .y_start      (y_start_r),
    .load_dir     (load_dir),
    .load_major   (load_major),
    .load_minor   (load_minor),
    .load_decision(load_decision),
    .line_active  (line_active),
    .pix_x        (pix_x),
    .pix_y        (pix_y),
    .pix_last     (pix_last)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = proc && emits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && emits) begin
      pixel_x_r <= pix_x;
      pixel_y_r <= pix_y;
      last_r    <= pix_last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_pixel_x = pixel_x_r;
  assign out_pixel_y = pixel_y_r;
  assign out_last    = last_r;

endmodule
